/* rtl/core/kwsm_pkg.sv */
// ----------------------------------------------------------------------------
// Keyword substring matcher package
// Keyword table, keyword list codes, cell control type and compare helpers.
// ----------------------------------------------------------------------------
package kwsm_pkg;

    localparam int unsigned KW_COUNT   = 53;
    localparam int unsigned KW_MAX_LEN = 16;
    localparam int unsigned KW_TEXT_W  = KW_MAX_LEN * 8;
    localparam int unsigned KW_LEN_W   = $clog2(KW_MAX_LEN + 1);

    // Keyword list selector codes
    typedef enum logic [1:0] {
        SET_NOISE      = 2'd0,
        SET_POST_NOISE = 2'd1,
        SET_POSITIVE   = 2'd2,
        SET_NEGATIVE   = 2'd3
    } kwsm_set_t;

    // Control handed to every window cell
    typedef struct packed {
        logic advance;  // shift the window by one byte
        logic clear;    // drop the window contents (end of string)
    } kwsm_ctrl_t;

    typedef logic [KW_TEXT_W-1:0] kwsm_text_t;

    // Keywords, right-justified: the last character sits in bits [7:0],
    // unused upper bytes are zero. Two noise entries are written in hex.
    localparam kwsm_text_t KW_TEXT [KW_COUNT] = '{
        KW_TEXT_W'("share"),      KW_TEXT_W'("sns"),        KW_TEXT_W'("social"),
        KW_TEXT_W'("related"),    KW_TEXT_W'("recommend"),  KW_TEXT_W'("endlink"),
        KW_TEXT_W'("comment"),    KW_TEXT_W'(48'h646973717573),
        KW_TEXT_W'("sidebar"),    KW_TEXT_W'("widget"),     KW_TEXT_W'("sponsored"),
        KW_TEXT_W'("sponsor"),    KW_TEXT_W'("promo"),      KW_TEXT_W'("banner"),
        KW_TEXT_W'(64'h6f7574627261696e),
        KW_TEXT_W'("newsletter"), KW_TEXT_W'("subscribe"),  KW_TEXT_W'("cookie"),
        KW_TEXT_W'("gdpr"),       KW_TEXT_W'("popup"),      KW_TEXT_W'("pagination"),
        KW_TEXT_W'("pager"),      KW_TEXT_W'("breadcrumb"), KW_TEXT_W'("masthead"),
        KW_TEXT_W'("menu"),       KW_TEXT_W'("byline"),     KW_TEXT_W'("keywords"),
        KW_TEXT_W'("tags"),
        KW_TEXT_W'("share"),      KW_TEXT_W'("social"),     KW_TEXT_W'("related"),
        KW_TEXT_W'("recommend"),  KW_TEXT_W'("advert"),     KW_TEXT_W'("ads"),
        KW_TEXT_W'("article"),    KW_TEXT_W'("body"),       KW_TEXT_W'("content"),
        KW_TEXT_W'("entry"),      KW_TEXT_W'("hentry"),     KW_TEXT_W'("main"),
        KW_TEXT_W'("page"),       KW_TEXT_W'("post"),       KW_TEXT_W'("text"),
        KW_TEXT_W'("blog"),       KW_TEXT_W'("story"),
        KW_TEXT_W'("hidden"),     KW_TEXT_W'("hid"),        KW_TEXT_W'("ad-"),
        KW_TEXT_W'("ads"),        KW_TEXT_W'("agegate"),    KW_TEXT_W'("popup"),
        KW_TEXT_W'("extra"),      KW_TEXT_W'("print")
    };

    localparam kwsm_set_t KW_LIST [KW_COUNT] = '{
        SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE,
        SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE,
        SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE,
        SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE, SET_NOISE,
        SET_POST_NOISE, SET_POST_NOISE, SET_POST_NOISE, SET_POST_NOISE,
        SET_POST_NOISE, SET_POST_NOISE,
        SET_POSITIVE, SET_POSITIVE, SET_POSITIVE, SET_POSITIVE, SET_POSITIVE,
        SET_POSITIVE, SET_POSITIVE, SET_POSITIVE, SET_POSITIVE, SET_POSITIVE,
        SET_POSITIVE,
        SET_NEGATIVE, SET_NEGATIVE, SET_NEGATIVE, SET_NEGATIVE, SET_NEGATIVE,
        SET_NEGATIVE, SET_NEGATIVE, SET_NEGATIVE
    };

    // Number of characters in a right-justified keyword
    function automatic logic [KW_LEN_W-1:0] kw_length(kwsm_text_t text);
        logic [KW_LEN_W-1:0] n;
        n = '0;
        for (int unsigned d = 0; d < KW_MAX_LEN; d++)
        begin
            if (text[d*8 +: 8] != 8'h00)
            begin
                n = KW_LEN_W'(d + 1);
            end
        end
        return n;
    endfunction

    // One bit per keyword: the byte at the given offset from the newest byte
    // agrees with that keyword, or the keyword is too short to reach it.
    function automatic logic [KW_COUNT-1:0] kw_column_eq(logic [7:0] b, int unsigned offset);
        logic [KW_COUNT-1:0] eq;
        for (int unsigned k = 0; k < KW_COUNT; k++)
        begin
            if (offset >= int'(kw_length(KW_TEXT[k])))
            begin
                eq[k] = 1'b1;
            end
            else
            begin
                eq[k] = (b == KW_TEXT[k][offset*8 +: 8]);
            end
        end
        return eq;
    endfunction

    // Keywords that fit in a window of the given span
    function automatic logic [KW_COUNT-1:0] kw_fit_mask(int unsigned longest);
        logic [KW_COUNT-1:0] fit;
        for (int unsigned k = 0; k < KW_COUNT; k++)
        begin
            fit[k] = (int'(kw_length(KW_TEXT[k])) <= int'(longest));
        end
        return fit;
    endfunction

endpackage

/* rtl/core/kwsm_cell.sv */
// ----------------------------------------------------------------------------
// Keyword matcher window cell
// Holds one case-folded byte of the window, passes it on at every shift and
// compares it against the keyword column for its distance.
// ----------------------------------------------------------------------------
module kwsm_cell #(
    parameter int unsigned POS = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kwsm_pkg::kwsm_ctrl_t          ctrl,
    input  logic [7:0]                    byte_in,
    output logic [7:0]                    byte_out,
    output logic [kwsm_pkg::KW_COUNT-1:0] eq
);
    import kwsm_pkg::*;

    logic [7:0] hold_reg;
    logic [7:0] hold_next;

    always_comb
    begin
        hold_next = hold_reg;
        if (ctrl.clear)
        begin
            hold_next = 8'h00;
        end
        else if (ctrl.advance)
        begin
            hold_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 8'h00;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

    assign byte_out = hold_reg;
    assign eq       = kw_column_eq(hold_reg, POS);

endmodule

/* rtl/core/keyword_substring_matcher.sv */
// ----------------------------------------------------------------------------
// Keyword substring matcher
// Streams one attribute string a byte at a time and reports at its last
// byte whether any keyword of the selected list occurs in it.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while no result stalls at the output,
// and returns one result per string, on the request marked tlast, in the
// cycle after that byte is taken. A request marked tlast with tuser set
// stands for an empty string and always returns 0. Letters A-Z are folded
// to lower case. The window is a row of LONGEST_KEYWORD-1 cells, each
// holding one earlier byte; every keyword is compared combinationally
// across the newest byte and all cells, so the sustained rate is one byte
// per cycle. A hit is held in a sticky flag until the string ends; window
// and flag then clear. The result sits in an output register, so a new byte
// is taken in the same cycle that a waiting result leaves. Each byte is
// checked against the list selected when it arrives. Keywords longer than
// LONGEST_KEYWORD never match. There is no clearing pass after reset.
// The user must write keyword_set through cfg_valid/cfg_data only while the
// block is idle; the block does not enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
module keyword_substring_matcher #(
    parameter int unsigned LONGEST_KEYWORD = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,     // [1:0] keyword_set
    // byte requests
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] char_byte
    input  logic       s_tlast,      // end_of_string
    input  logic       s_tuser,      // [0] empty_string
    // results
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata       // [0] matched, [7:1] zero
);
    import kwsm_pkg::*;

    localparam int unsigned WINDOW_DEPTH = LONGEST_KEYWORD - 1;
    localparam logic [KW_COUNT-1:0] FIT_MASK = kw_fit_mask(LONGEST_KEYWORD);

    kwsm_set_t           keyword_set_reg;
    logic                hit_seen_reg;
    logic                hit_seen_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                matched_reg;
    logic                matched_next;

    logic                accept;
    logic [7:0]          cur_byte;
    kwsm_ctrl_t          ctrl;
    logic [7:0]          chain [WINDOW_DEPTH];
    logic [KW_COUNT-1:0] eq_vec [WINDOW_DEPTH + 1];
    logic [KW_COUNT-1:0] all_eq;
    logic [KW_COUNT-1:0] sel_mask;
    logic                hit_now;

    // ---------------------------------------------------------------------
    // Configuration: always ready, take the list selector on a request
    // ---------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keyword_set_reg <= SET_NOISE;
        end
        else if (cfg_valid)
        begin
            keyword_set_reg <= kwsm_set_t'(cfg_data);
        end
    end

    // ---------------------------------------------------------------------
    // Handshake: take a byte whenever the result register is free or its
    // result leaves in this cycle
    // ---------------------------------------------------------------------
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign ctrl.advance = accept;
    assign ctrl.clear   = accept && s_tlast;

    // Fold upper-case ASCII letters to lower case
    always_comb
    begin
        cur_byte = s_tdata;
        if (s_tdata >= 8'h41 && s_tdata <= 8'h5A)
        begin
            cur_byte = s_tdata + 8'h20;
        end
    end

    // ---------------------------------------------------------------------
    // Window: the newest byte enters the first cell, each cell hands its
    // byte on to the next at every shift
    // ---------------------------------------------------------------------
    assign chain[0]  = cur_byte;
    assign eq_vec[0] = kw_column_eq(cur_byte, 0);

    for (genvar i = 1; i <= WINDOW_DEPTH; i++)
    begin : g_cell
        if (i < WINDOW_DEPTH)
        begin : g_mid
            kwsm_cell #(
                .POS (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .byte_in  (chain[i-1]),
                .byte_out (chain[i]),
                .eq       (eq_vec[i])
            );
        end
        else
        begin : g_last
            kwsm_cell #(
                .POS (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .byte_in  (chain[i-1]),
                .byte_out (),
                .eq       (eq_vec[i])
            );
        end
    end

    // Combine the per-cell columns: a keyword hits when every position agrees
    always_comb
    begin
        all_eq = '1;
        for (int unsigned i = 0; i <= WINDOW_DEPTH; i++)
        begin
            all_eq = all_eq & eq_vec[i];
        end
    end

    always_comb
    begin
        for (int unsigned k = 0; k < KW_COUNT; k++)
        begin
            sel_mask[k] = (KW_LIST[k] == keyword_set_reg);
        end
    end

    assign hit_now = |(all_eq & sel_mask & FIT_MASK);

    // ---------------------------------------------------------------------
    // Sticky hit flag and result register
    // ---------------------------------------------------------------------
    always_comb
    begin
        hit_seen_next  = hit_seen_reg;
        out_valid_next = out_valid_reg;
        matched_next   = matched_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (s_tlast)
            begin
                // end of string: hand out the result, drop the flag
                hit_seen_next  = 1'b0;
                out_valid_next = 1'b1;
                matched_next   = !s_tuser && (hit_seen_reg || hit_now);
            end
            else
            begin
                hit_seen_next = hit_seen_reg || hit_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hit_seen_reg  <= hit_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, matched_reg};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_result_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result raised without an end-of-string request");

    a_empty_gives_zero : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast && s_tuser |=> m_tvalid && !m_tdata[0])
        else $error("empty string did not return zero");

    a_flag_cleared : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !hit_seen_reg)
        else $error("hit flag survived the end of a string");

    a_hit_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_tlast && hit_now |=> hit_seen_reg)
        else $error("keyword hit was not collected");

    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("byte taken while a result is stalled");

endmodule
